// ===== design/kcrm_pkg.sv =====
package kcrm_pkg;

	// Table and key sizes
	localparam int MAX_RULES      = 16;
	localparam int MAX_CHORD_KEYS = 4;
	localparam int PACKED_KEYS    = 4;
	localparam int USABLE_KEYS    = (MAX_CHORD_KEYS < PACKED_KEYS) ? MAX_CHORD_KEYS : PACKED_KEYS;
	localparam int KEY_W          = 8;
	localparam int KEY_SPACE      = 1 << KEY_W;
	localparam int RULE_IDX_W     = $clog2(MAX_RULES);
	localparam int RULE_CNT_W     = 5;
	localparam int KCNT_W         = 3;
	localparam int KIDX_W         = 2;
	localparam int SRC_W          = 2;
	localparam int FIRED_W        = 4;
	localparam int KEYS_W         = PACKED_KEYS * KEY_W;

	// Source filter codes
	localparam logic [SRC_W-1:0] SRC_ANY    = 2'd0;
	localparam logic [SRC_W-1:0] SRC_LOCAL  = 2'd1;
	localparam logic [SRC_W-1:0] SRC_REMOTE = 2'd2;

	// One stored chord rule
	typedef struct packed {
		logic              enabled;
		logic [SRC_W-1:0]  source;
		logic              on_release;
		logic [KCNT_W-1:0] key_count;
		logic [KEYS_W-1:0] keys;
	} rule_t;

	// Controller to datapath
	typedef struct packed {
		logic latch;
		logic cfg_wr;
		logic rule_wr;
		logic map_wr;
		logic scan_start;
		logic rule_next;
		logic key_clr;
		logic key_step;
		logic out_load;
		logic out_hit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_write;
		logic is_bypass;
		logic is_own;
		logic rule_last;
		logic rule_ok;
		logic key_more;
		logic key_pend;
		logic key_fail;
		logic out_free;
	} sts_t;

endpackage

// ===== design/key_chord_rule_matcher.sv =====
// Key chord rule matcher. Each request is either a rule write (action 1), which stores one
// of 16 rule slots, or a key event, which updates a 256-entry held-key map (unless bypass)
// and, if not our own event, scans rule slots 0 .. min(active_rules, 16)-1 for the first
// chord that fires. Every request yields exactly one result. One request is in work at a
// time: a rule write, a bypassed or own event goes from decode straight to the done state. A
// scan steps through the rules in order; for each rule whose enable, source, edge and key
// filters pass, its trigger keys are read one per cycle through the single read port of the
// held-key map. The next request is accepted while the previous result still waits in the
// output register. The held-key map clears at reset through per-key valid flags, so no
// clearing pass is needed. active_rules is written through the cfg port, which is ready
// only while no request is in work.
module key_chord_rule_matcher (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             action,
	input  logic [kcrm_pkg::KEY_W-1:0]       key_code,
	input  logic                             key_up,
	input  logic                             injected,
	input  logic                             own_event,
	input  logic                             bypass,
	input  logic [3:0]                       rule_slot,
	input  logic                             rule_enabled,
	input  logic [kcrm_pkg::SRC_W-1:0]       rule_source,
	input  logic                             rule_on_release,
	input  logic [kcrm_pkg::KCNT_W-1:0]      rule_key_count,
	input  logic [kcrm_pkg::KEYS_W-1:0]      rule_keys,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [kcrm_pkg::RULE_CNT_W-1:0]  cfg_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             consumed,
	output logic [kcrm_pkg::FIRED_W-1:0]     fired_rule
);
	import kcrm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	kcrm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kcrm_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_data        (cfg_data),
		.action          (action),
		.key_code        (key_code),
		.key_up          (key_up),
		.injected        (injected),
		.own_event       (own_event),
		.bypass          (bypass),
		.rule_slot       (rule_slot),
		.rule_enabled    (rule_enabled),
		.rule_source     (rule_source),
		.rule_on_release (rule_on_release),
		.rule_key_count  (rule_key_count),
		.rule_keys       (rule_keys),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.consumed        (consumed),
		.fired_rule      (fired_rule)
	);

	// A result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded while output register busy");

	// One request at a time: an accept is followed by a stalled cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while another is in work");

	// A firing rule lies inside the scanned range
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.out_hit) |-> !sts.rule_last)
		else $error("reported rule outside scan range");

endmodule

// ===== design/kcrm_datapath.sv =====
module kcrm_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  kcrm_pkg::cmd_t                   cmd,
	output kcrm_pkg::sts_t                   sts,
	input  logic [kcrm_pkg::RULE_CNT_W-1:0]  cfg_data,
	input  logic                             action,
	input  logic [kcrm_pkg::KEY_W-1:0]       key_code,
	input  logic                             key_up,
	input  logic                             injected,
	input  logic                             own_event,
	input  logic                             bypass,
	input  logic [3:0]                       rule_slot,
	input  logic                             rule_enabled,
	input  logic [kcrm_pkg::SRC_W-1:0]       rule_source,
	input  logic                             rule_on_release,
	input  logic [kcrm_pkg::KCNT_W-1:0]      rule_key_count,
	input  logic [kcrm_pkg::KEYS_W-1:0]      rule_keys,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic                             consumed,
	output logic [kcrm_pkg::FIRED_W-1:0]     fired_rule
);
	import kcrm_pkg::*;

	// Latched request
	logic              act_q, up_q, inj_q, own_q, byp_q;
	logic [KEY_W-1:0]  key_q;
	logic [3:0]        slot_q;
	rule_t             wr_rule_q;

	// Configuration, rule table and held-key map
	logic [RULE_CNT_W-1:0] active_q;
	rule_t                 rule_tab_q [MAX_RULES];
	logic                  held_mem [KEY_SPACE];
	logic [KEY_SPACE-1:0]  held_vld_q;

	// Scan counters and held-map read stage
	logic [RULE_CNT_W-1:0] rule_ctr_q;
	logic [KCNT_W-1:0]     key_ctr_q;
	logic                  pend_s1, need_s1, held_s1, held_vld_s1;

	// Result register
	logic               out_valid_q, consumed_q;
	logic [FIRED_W-1:0] fired_q;

	rule_t                 cur;
	logic [RULE_CNT_W-1:0] n_lim;
	logic [KCNT_W-1:0]     use_cnt;
	logic [KEY_W-1:0]      rd_addr;
	logic                  found, src_ok, key_more;

	// Request capture and rule writes
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q     <= action;
			key_q     <= key_code;
			up_q      <= key_up;
			inj_q     <= injected;
			own_q     <= own_event;
			byp_q     <= bypass;
			slot_q    <= rule_slot;
			wr_rule_q <= '{enabled: rule_enabled, source: rule_source,
				on_release: rule_on_release, key_count: rule_key_count, keys: rule_keys};
		end
		if (cmd.rule_wr && ({1'b0, slot_q} < 5'(MAX_RULES)))
			rule_tab_q[slot_q[RULE_IDX_W-1:0]] <= wr_rule_q;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			active_q <= '0;
		else if (cmd.cfg_wr)
			active_q <= cfg_data;
	end

	// Current rule and its static checks
	assign cur     = rule_tab_q[rule_ctr_q[RULE_IDX_W-1:0]];
	assign n_lim   = (active_q > RULE_CNT_W'(MAX_RULES)) ? RULE_CNT_W'(MAX_RULES) : active_q;
	assign use_cnt = (cur.key_count > KCNT_W'(USABLE_KEYS)) ? KCNT_W'(USABLE_KEYS)
		: cur.key_count;

	always_comb begin
		found = 1'b0;
		for (int j = 0; j < PACKED_KEYS; j++) begin
			if ((KCNT_W'(j) < use_cnt) && (cur.keys[j*KEY_W +: KEY_W] == key_q))
				found = 1'b1;
		end
	end

	assign src_ok = !((cur.source == SRC_LOCAL) && inj_q)
		&& !((cur.source == SRC_REMOTE) && !inj_q);
	assign rd_addr  = cur.keys[key_ctr_q[KIDX_W-1:0]*KEY_W +: KEY_W];
	assign key_more = key_ctr_q < use_cnt;

	// Held-key map: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.map_wr)
			held_mem[key_q] <= !up_q;
		held_s1     <= held_mem[rd_addr];
		held_vld_s1 <= held_vld_q[rd_addr];
		need_s1     <= !(cur.on_release && (rd_addr == key_q));
	end

	// Entries never written read as released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			held_vld_q <= '0;
		else if (cmd.map_wr)
			held_vld_q[key_q] <= 1'b1;
	end

	// Rule and key counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_ctr_q <= '0;
			key_ctr_q  <= '0;
			pend_s1    <= 1'b0;
		end else begin
			if (cmd.scan_start)
				rule_ctr_q <= '0;
			else if (cmd.rule_next)
				rule_ctr_q <= rule_ctr_q + 1'b1;
			if (cmd.key_clr)
				key_ctr_q <= '0;
			else if (cmd.key_step && key_more)
				key_ctr_q <= key_ctr_q + 1'b1;
			pend_s1 <= cmd.key_step && key_more;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			consumed_q <= cmd.out_hit;
			fired_q    <= cmd.out_hit ? rule_ctr_q[FIRED_W-1:0] : '0;
		end
	end

	// Status to the controller
	assign sts.is_write  = act_q;
	assign sts.is_bypass = byp_q;
	assign sts.is_own    = own_q;
	assign sts.rule_last = rule_ctr_q >= n_lim;
	assign sts.rule_ok   = cur.enabled && src_ok && (cur.on_release == up_q) && found;
	assign sts.key_more  = key_more;
	assign sts.key_pend  = pend_s1;
	assign sts.key_fail  = pend_s1 && need_s1 && !(held_vld_s1 && held_s1);
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign consumed   = consumed_q;
	assign fired_rule = fired_q;

endmodule

// ===== design/kcrm_ctrl.sv =====
module kcrm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  kcrm_pkg::sts_t sts,
	output kcrm_pkg::cmd_t cmd
);
	import kcrm_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DEC  = 5'b00010,
		S_RULE = 5'b00100,
		S_KEY  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   hit_q, hit_d;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		hit_d   = hit_q;
		cmd     = '0;
		cmd.cfg_wr = cfg_valid && (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DEC;
				end
			end
			S_DEC: begin
				hit_d = 1'b0;
				if (sts.is_write) begin
					cmd.rule_wr = 1'b1;
					state_d     = S_DONE;
				end else if (sts.is_bypass) begin
					state_d = S_DONE;
				end else begin
					cmd.map_wr = 1'b1;
					if (sts.is_own) begin
						state_d = S_DONE;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_RULE;
					end
				end
			end
			S_RULE: begin
				cmd.key_clr = 1'b1;
				if (sts.rule_last)
					state_d = S_DONE;
				else if (sts.rule_ok)
					state_d = S_KEY;
				else
					cmd.rule_next = 1'b1;
			end
			S_KEY: begin
				if (sts.key_fail) begin
					cmd.rule_next = 1'b1;
					state_d       = S_RULE;
				end else if (!sts.key_more && !sts.key_pend) begin
					hit_d   = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.key_step = 1'b1;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_hit  = hit_q;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			hit_q   <= hit_d;
		end
	end

endmodule

// ===== tb/key_chord_rule_matcher_test.sv =====
`timescale 1ns / 1ps

module key_chord_rule_matcher_test;
	import kcrm_pkg::*;

	localparam logic ACT_KEY     = 1'b0;
	localparam logic ACT_RULE    = 1'b1;
	localparam logic KEY_PRESS   = 1'b0;
	localparam logic KEY_RELEASE = 1'b1;
	localparam int   CYCLE_LIMIT = 1_500_000;
	localparam int   DRAIN_CYCLES = 120;

	// One request as the sender sees it; rule fields ride along on key events as noise
	typedef struct {
		logic              action;
		logic [KEY_W-1:0]  key_code;
		logic              key_up;
		logic              injected;
		logic              own_event;
		logic              bypass;
		logic [3:0]        rule_slot;
		rule_t             rule;
	} chord_request_t;

	typedef struct packed {
		logic               consumed;
		logic [FIRED_W-1:0] fired;
	} verdict_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  action;
	logic [KEY_W-1:0]      key_code;
	logic                  key_up;
	logic                  injected;
	logic                  own_event;
	logic                  bypass;
	logic [3:0]            rule_slot;
	logic                  rule_enabled;
	logic [SRC_W-1:0]      rule_source;
	logic                  rule_on_release;
	logic [KCNT_W-1:0]     rule_key_count;
	logic [KEYS_W-1:0]     rule_keys;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [RULE_CNT_W-1:0] cfg_data;
	logic                  out_valid;
	logic                  out_stall;
	logic                  consumed;
	logic [FIRED_W-1:0]    fired_rule;

	// Predictor state
	logic [KEY_SPACE-1:0]  held_map;
	rule_t                 chord_table [MAX_RULES];
	logic [RULE_CNT_W-1:0] active_cnt;
	verdict_t              pending_verdicts [$];

	// Keys that random rules and chord sequences share, so chords actually get held
	logic [KEY_W-1:0] key_pool [8] = '{8'h00, 8'h11, 8'h2A, 8'h41, 8'h5B, 8'hA0, 8'hE7, 8'hFF};

	int idle_pct;
	int stall_pct;
	int cycle_count;
	int err_count;
	int n_sent;
	int n_rule_writes;
	int n_results;
	int n_swallowed;

	key_chord_rule_matcher uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.key_code        (key_code),
		.key_up          (key_up),
		.injected        (injected),
		.own_event       (own_event),
		.bypass          (bypass),
		.rule_slot       (rule_slot),
		.rule_enabled    (rule_enabled),
		.rule_source     (rule_source),
		.rule_on_release (rule_on_release),
		.rule_key_count  (rule_key_count),
		.rule_keys       (rule_keys),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.consumed        (consumed),
		.fired_rule      (fired_rule)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Cycle count and run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run limit hit at cycle %0d with %0d results outstanding",
				cycle_count, pending_verdicts.size());
			$display("[key_chord_rule_matcher] ERROR");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		err_count++;
	endtask

	// Result checker: compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("unexpected result consumed=%0b fired_rule=%0d",
					consumed, fired_rule));
			end else begin
				want = pending_verdicts.pop_front();
				n_results++;
				if (want.consumed)
					n_swallowed++;
				if (consumed !== want.consumed)
					report_mismatch($sformatf("consumed %b, want %b", consumed, want.consumed));
				if (fired_rule !== want.fired)
					report_mismatch($sformatf("fired_rule %0d, want %0d", fired_rule, want.fired));
			end
		end
	end

	// Does one stored rule fire for this event, given the current held map?
	function automatic bit chord_fires(input rule_t rl, input logic [KEY_W-1:0] code,
			input logic up, input logic inj);
		int n;
		bit found;
		logic [KEY_W-1:0] tk;
		if (!rl.enabled)
			return 0;
		if (rl.source == SRC_LOCAL && inj)
			return 0;
		if (rl.source == SRC_REMOTE && !inj)
			return 0;
		if (rl.on_release != up)
			return 0;
		n = (rl.key_count > USABLE_KEYS) ? USABLE_KEYS : rl.key_count;
		found = 0;
		for (int j = 0; j < n; j++)
			if (rl.keys[j*KEY_W +: KEY_W] == code)
				found = 1;
		if (!found)
			return 0;
		// released trigger itself need not be held
		for (int j = 0; j < n; j++) begin
			tk = rl.keys[j*KEY_W +: KEY_W];
			if (!(up && tk == code) && !held_map[tk])
				return 0;
		end
		return 1;
	endfunction

	// Updates predictor state for one accepted request and returns its verdict
	function automatic verdict_t predict_verdict(input chord_request_t rq);
		verdict_t res;
		int span;
		res = '0;
		if (rq.action == ACT_RULE) begin
			chord_table[rq.rule_slot] = rq.rule;
			return res;
		end
		if (rq.bypass)
			return res;
		held_map[rq.key_code] = (rq.key_up == KEY_PRESS);
		if (rq.own_event)
			return res;
		span = (active_cnt > MAX_RULES) ? MAX_RULES : active_cnt;
		for (int i = 0; i < span; i++) begin
			if (chord_fires(chord_table[i], rq.key_code, rq.key_up, rq.injected)) begin
				res.consumed = 1'b1;
				res.fired = FIRED_W'(i);
				return res;
			end
		end
		return res;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 4) == 0)
			return KEY_W'($urandom_range(0, KEY_SPACE - 1));
		return key_pool[$urandom_range(0, 7)];
	endfunction

	function automatic rule_t mk_rule(input logic en, input logic [SRC_W-1:0] src,
			input logic rel, input logic [KCNT_W-1:0] cnt, input logic [KEYS_W-1:0] keys);
		rule_t rl;
		rl.enabled = en;
		rl.source = src;
		rl.on_release = rel;
		rl.key_count = cnt;
		rl.keys = keys;
		return rl;
	endfunction

	function automatic rule_t random_rule();
		rule_t rl;
		rl.enabled = ($urandom_range(0, 9) != 0);
		rl.source = SRC_W'($urandom_range(0, 3));
		rl.on_release = 1'($urandom_range(0, 1));
		rl.key_count = ($urandom_range(0, 4) != 0) ? KCNT_W'($urandom_range(1, 4))
			: KCNT_W'($urandom_range(0, 7));
		if ($urandom_range(0, 7) == 0)
			rl.keys = $urandom;
		else
			for (int j = 0; j < PACKED_KEYS; j++)
				rl.keys[j*KEY_W +: KEY_W] = pick_key();
		return rl;
	endfunction

	function automatic chord_request_t make_event(input logic [KEY_W-1:0] code, input logic up,
			input logic inj);
		chord_request_t rq;
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		rq.action = ACT_KEY;
		rq.key_code = code;
		rq.key_up = up;
		rq.injected = inj;
		rq.own_event = 1'b0;
		rq.bypass = 1'b0;
		rq.rule_slot = noise[42:39];
		rq.rule = noise[38:0];
		return rq;
	endfunction

	function automatic chord_request_t make_rule_write(input logic [3:0] slot, input rule_t rl);
		chord_request_t rq;
		logic [31:0] noise;
		noise = $urandom;
		rq.action = ACT_RULE;
		rq.key_code = noise[7:0];
		rq.key_up = noise[8];
		rq.injected = noise[9];
		rq.own_event = noise[10];
		rq.bypass = noise[11];
		rq.rule_slot = slot;
		rq.rule = rl;
		return rq;
	endfunction

	// Send one request: optional idle gap, then hold it until accepted
	task automatic send_request(input chord_request_t rq);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		action          <= rq.action;
		key_code        <= rq.key_code;
		key_up          <= rq.key_up;
		injected        <= rq.injected;
		own_event       <= rq.own_event;
		bypass          <= rq.bypass;
		rule_slot       <= rq.rule_slot;
		rule_enabled    <= rq.rule.enabled;
		rule_source     <= rq.rule.source;
		rule_on_release <= rq.rule.on_release;
		rule_key_count  <= rq.rule.key_count;
		rule_keys       <= rq.rule.keys;
		do @(posedge clk); while (in_stall);
		pending_verdicts.push_back(predict_verdict(rq));
		n_sent++;
		if (rq.action == ACT_RULE)
			n_rule_writes++;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// active_rules is only written with the block idle
	task automatic write_active_rules(input logic [RULE_CNT_W-1:0] cnt);
		wait_for_results();
		cfg_valid <= 1'b1;
		cfg_data  <= cnt;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		active_cnt = cnt;
	endtask

	// Hold the other triggers of a stored rule, then hit its trigger edge
	task automatic play_chord();
		rule_t rl;
		int span, slot, n, trig;
		logic inj;
		span = (active_cnt > MAX_RULES) ? MAX_RULES : active_cnt;
		slot = (span == 0) ? $urandom_range(0, MAX_RULES - 1) : $urandom_range(0, span - 1);
		rl = chord_table[slot];
		n = (rl.key_count > USABLE_KEYS) ? USABLE_KEYS : rl.key_count;
		case (rl.source)
			SRC_LOCAL: inj = 1'b0;
			SRC_REMOTE: inj = 1'b1;
			default: inj = 1'($urandom_range(0, 1));
		endcase
		if ($urandom_range(0, 6) == 0)
			inj = !inj;
		if (n == 0) begin
			send_request(make_event(pick_key(), rl.on_release, inj));
			return;
		end
		trig = $urandom_range(0, n - 1);
		for (int j = 0; j < n; j++)
			if (j != trig && $urandom_range(0, 9) != 0)
				send_request(make_event(rl.keys[j*KEY_W +: KEY_W], KEY_PRESS, inj));
		if (rl.on_release && $urandom_range(0, 1))
			send_request(make_event(rl.keys[trig*KEY_W +: KEY_W], KEY_PRESS, inj));
		send_request(make_event(rl.keys[trig*KEY_W +: KEY_W], rl.on_release, inj));
		for (int j = 0; j < n; j++)
			if ($urandom_range(0, 1))
				send_request(make_event(rl.keys[j*KEY_W +: KEY_W], KEY_RELEASE,
					1'($urandom_range(0, 1))));
	endtask

	// Mix of chord sequences, rule rewrites and loose events
	task automatic random_step();
		chord_request_t rq;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			play_chord();
		end else if (pick < 47) begin
			send_request(make_rule_write(4'($urandom_range(0, MAX_RULES - 1)), random_rule()));
		end else begin
			rq = make_event(pick_key(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			rq.own_event = ($urandom_range(0, 11) == 0);
			rq.bypass = ($urandom_range(0, 11) == 0);
			send_request(rq);
		end
	endtask

	// Fill every slot before any scan can look at one
	task automatic test_rule_load();
		send_request(make_rule_write(4'd0, mk_rule(1'b0, SRC_ANY, 1'b0, 3'd2, 32'h0000_2A11)));
		send_request(make_rule_write(4'd1, mk_rule(1'b1, SRC_ANY, 1'b0, 3'd2, 32'h0000_2A11)));
		send_request(make_rule_write(4'd2, mk_rule(1'b1, SRC_LOCAL, 1'b0, 3'd1, 32'h0000_0000)));
		send_request(make_rule_write(4'd3, mk_rule(1'b1, SRC_REMOTE, 1'b0, 3'd1, 32'h0000_00FF)));
		send_request(make_rule_write(4'd4, mk_rule(1'b1, SRC_ANY, 1'b1, 3'd2, 32'h0000_5B41)));
		// source code three and a key count past the packed width
		send_request(make_rule_write(4'd5, mk_rule(1'b1, 2'd3, 1'b0, 3'd7, 32'hA0A0_A0A0)));
		// no trigger keys: never fires
		send_request(make_rule_write(4'd6, mk_rule(1'b1, SRC_ANY, 1'b0, 3'd0, 32'h0000_0033)));
		for (int s = 7; s < MAX_RULES - 1; s++)
			send_request(make_rule_write(4'(s),
				mk_rule(1'b0, 2'd3, 1'b1, 3'd4, (s == 7) ? 32'hFFFF_FFFF : $urandom)));
		send_request(make_rule_write(4'd15, mk_rule(1'b1, SRC_ANY, 1'b0, 3'd1, 32'h0000_0077)));
	endtask

	task automatic test_directed_events();
		chord_request_t rq;
		write_active_rules(5'd16);
		send_request(make_event(8'h00, KEY_PRESS, 1'b0));
		send_request(make_event(8'h00, KEY_PRESS, 1'b1));
		send_request(make_event(8'hFF, KEY_PRESS, 1'b1));
		send_request(make_event(8'hFF, KEY_PRESS, 1'b0));
		send_request(make_event(8'h11, KEY_PRESS, 1'b0));
		send_request(make_event(8'h2A, KEY_PRESS, 1'b1));
		// bypassed press leaves the map alone, so the release chord stays cold
		rq = make_event(8'h41, KEY_PRESS, 1'b0);
		rq.bypass = 1'b1;
		send_request(rq);
		send_request(make_event(8'h5B, KEY_RELEASE, 1'b0));
		// own event updates the map but is not scanned
		rq = make_event(8'h41, KEY_PRESS, 1'b0);
		rq.own_event = 1'b1;
		send_request(rq);
		send_request(make_event(8'h5B, KEY_RELEASE, 1'b0));
		send_request(make_event(8'hA0, KEY_PRESS, 1'b1));
		send_request(make_event(8'h33, KEY_PRESS, 1'b0));
		send_request(make_event(8'h77, KEY_PRESS, 1'b0));
		send_request(make_event(8'h11, KEY_RELEASE, 1'b0));
		send_request(make_event(8'h2A, KEY_PRESS, 1'b0));
	endtask

	// Scan lengths at and beyond the table size, and none at all
	task automatic test_active_rule_limits();
		logic [RULE_CNT_W-1:0] counts [6] = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd16, 5'd8};
		int target;
		idle_pct = 20;
		stall_pct = 20;
		foreach (counts[k]) begin
			write_active_rules(counts[k]);
			target = n_sent + 30;
			while (n_sent < target)
				random_step();
		end
	endtask

	// Four idle/stall mixes; each phase starts from a drained block
	task automatic test_random_traffic();
		int idle_mix [4] = '{0, 68, 0, 35};
		int stall_mix [4] = '{0, 0, 68, 35};
		int target;
		for (int p = 0; p < 4; p++) begin
			write_active_rules(RULE_CNT_W'($urandom_range(4, 20)));
			idle_pct = idle_mix[p];
			stall_pct = stall_mix[p];
			target = n_sent + 300;
			while (n_sent < target)
				random_step();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_KEY;
		key_code = '0;
		key_up = KEY_PRESS;
		injected = 1'b0;
		own_event = 1'b0;
		bypass = 1'b0;
		rule_slot = '0;
		rule_enabled = 1'b0;
		rule_source = SRC_ANY;
		rule_on_release = 1'b0;
		rule_key_count = '0;
		rule_keys = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		out_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		held_map = '0;
		active_cnt = '0;
		foreach (chord_table[s])
			chord_table[s] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rule_load();
		test_directed_events();
		test_active_rule_limits();
		test_random_traffic();

		idle_pct = 0;
		stall_pct = 0;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests (%0d rule writes), %0d results checked, %0d swallowed",
			n_sent, n_rule_writes, n_results, n_swallowed);
		$display("scan lengths 0 to 31 under four idle/stall mixes, %0d mismatches", err_count);
		if (err_count == 0 && pending_verdicts.size() == 0)
			$display("[key_chord_rule_matcher] OK");
		else
			$display("[key_chord_rule_matcher] ERROR");
		$finish;
	end

endmodule
